/* hdl/hte_pkg.sv */
// Hack text encoder package: character and status codes, line state type,
// and the comp, dest and jump mnemonic tables. No dependencies.
package hte_pkg;

	localparam int FIELD_CHARS_DEF = 3;

	typedef logic [7:0] char_t;

	// characters
	localparam char_t CH_LF   = 8'd10;
	localparam char_t CH_CR   = 8'd13;
	localparam char_t CH_AT   = "@";
	localparam char_t CH_EQ   = "=";
	localparam char_t CH_SEMI = ";";
	localparam char_t CH_A    = "A";
	localparam char_t CH_D    = "D";
	localparam char_t CH_M    = "M";
	localparam char_t CH_J    = "J";
	localparam char_t CH_0    = "0";
	localparam char_t CH_1    = "1";
	localparam char_t CH_9    = "9";
	localparam char_t CH_NEG  = "-";
	localparam char_t CH_NOT  = "!";

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_INSTR = 3'd1;
	localparam logic [2:0] ST_BAD_COMP  = 3'd2;
	localparam logic [2:0] ST_BAD_DEST  = 3'd3;
	localparam logic [2:0] ST_BAD_JUMP  = 3'd4;
	localparam logic [2:0] ST_ADDR_OVER = 3'd5;

	// line kinds
	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_ADDR  = 2'd1;
	localparam logic [1:0] KIND_COMP  = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	// sections of a compute line
	localparam logic [1:0] SEC_FIRST  = 2'd0;  // dest or comp, not yet known
	localparam logic [1:0] SEC_COMP   = 2'd1;  // comp after '='
	localparam logic [1:0] SEC_JUMP_D = 2'd2;  // jump after '=' and ';'
	localparam logic [1:0] SEC_JUMP   = 2'd3;  // jump after ';' with no dest

	localparam logic [14:0] ADDR_MAX = 15'h7FFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  section;
		logic [2:0]  err;
		logic        addr_seen;
		logic        addr_over;
		logic [14:0] addr;
	} line_state_t;

	// returns {hit, cccccc}; M already folded to A
	function automatic logic [6:0] comp_lookup(input logic [1:0] n, input char_t c0,
			input char_t c1, input char_t c2);
		logic [6:0] r;
		r = '0;
		unique case (n)
			2'd1: begin
				unique case (c0)
					"0": r = {1'b1, 6'h2A};
					"1": r = {1'b1, 6'h3F};
					"D": r = {1'b1, 6'h0C};
					"A": r = {1'b1, 6'h30};
					default: r = '0;
				endcase
			end
			2'd2: begin
				unique case ({c0, c1})
					"-1": r = {1'b1, 6'h3A};
					"!D": r = {1'b1, 6'h0D};
					"!A": r = {1'b1, 6'h31};
					"-D": r = {1'b1, 6'h0F};
					"-A": r = {1'b1, 6'h33};
					default: r = '0;
				endcase
			end
			2'd3: begin
				unique case ({c0, c1, c2})
					"D+1": r = {1'b1, 6'h1F};
					"A+1": r = {1'b1, 6'h37};
					"D-1": r = {1'b1, 6'h0E};
					"A-1": r = {1'b1, 6'h32};
					"D+A": r = {1'b1, 6'h02};
					"D-A": r = {1'b1, 6'h13};
					"A-D": r = {1'b1, 6'h07};
					"D&A": r = {1'b1, 6'h00};
					"D|A": r = {1'b1, 6'h15};
					default: r = '0;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] dest_bit(input char_t c);
		logic [2:0] b;
		unique case (c)
			CH_A: b = 3'b100;
			CH_D: b = 3'b010;
			CH_M: b = 3'b001;
			default: b = 3'b000;
		endcase
		return b;
	endfunction

	// returns {hit, jjj} for the two letters after 'J'
	function automatic logic [3:0] jump_lookup(input char_t c1, input char_t c2);
		logic [3:0] r;
		unique case ({c1, c2})
			"GT": r = 4'b1_001;
			"EQ": r = 4'b1_010;
			"GE": r = 4'b1_011;
			"LT": r = 4'b1_100;
			"NE": r = 4'b1_101;
			"LE": r = 4'b1_110;
			"MP": r = 4'b1_111;
			default: r = 4'b0_000;
		endcase
		return r;
	endfunction

endpackage

/* hdl/hte_line_decode.sv */
// End-of-line encoder: turns the collected line state and field text into a
// machine word and status. Combinational. Depends on hte_pkg.
module hte_line_decode #(
	parameter int FIELD_CHARS = hte_pkg::FIELD_CHARS_DEF,
	localparam int LEN_W = $clog2(FIELD_CHARS + 2)
) (
	input  hte_pkg::line_state_t st,
	input  hte_pkg::char_t       chars [3][FIELD_CHARS],
	input  logic [LEN_W-1:0]     lens  [3],
	output logic [15:0]          machine_word,
	output logic [2:0]           status
);
	import hte_pkg::*;

	logic             has_dest, has_jump;
	logic [LEN_W-1:0] clen;
	char_t            cch [3];
	logic             has_a, has_m, comp_ok;
	logic [6:0]       comp_hit;
	logic [2:0]       dbits, db;
	logic             dest_ok;
	logic [3:0]       jump_hit;
	logic             jump_ok;
	logic [15:0]      word;
	logic [2:0]       stat;

	assign has_dest = (st.section == SEC_COMP) || (st.section == SEC_JUMP_D);
	assign has_jump = (st.section == SEC_JUMP_D) || (st.section == SEC_JUMP);
	assign clen = has_dest ? lens[1] : lens[0];

	// comp: fold M to A, reject mixing A and M
	always_comb begin
		has_a = 1'b0;
		has_m = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cch[i] = has_dest ? chars[1][i] : chars[0][i];
			if (LEN_W'(i) < clen) begin
				if (cch[i] == CH_A) has_a = 1'b1;
				if (cch[i] == CH_M) begin
					has_m  = 1'b1;
					cch[i] = CH_A;
				end
			end
		end
		comp_hit = comp_lookup(clen[1:0], cch[0], cch[1], cch[2]);
		comp_ok  = (clen != '0) && (clen <= LEN_W'(3)) && !(has_a && has_m) && comp_hit[6];
	end

	// dest: distinct letters from A, D, M
	always_comb begin
		dbits   = 3'b000;
		dest_ok = (lens[0] != '0) && (lens[0] <= LEN_W'(3));
		db      = 3'b000;
		for (int i = 0; i < 3; i++) begin
			if (LEN_W'(i) < lens[0]) begin
				db = dest_bit(chars[0][i]);
				if (db == 3'b000 || (dbits & db) != 3'b000) dest_ok = 1'b0;
				dbits = dbits | db;
			end
		end
	end

	always_comb begin
		jump_hit = jump_lookup(chars[2][1], chars[2][2]);
		jump_ok  = (lens[2] == LEN_W'(3)) && (chars[2][0] == CH_J) && jump_hit[3];
	end

	always_comb begin
		word = '0;
		stat = ST_OK;
		unique case (st.kind)
			KIND_ADDR: begin
				if (st.err != ST_OK || !st.addr_seen) stat = ST_NOT_INSTR;
				else if (st.addr_over)                stat = ST_ADDR_OVER;
				else                                  word = {1'b0, st.addr};
			end
			KIND_COMP: begin
				if (st.err != ST_OK)               stat = st.err;
				else if (!comp_ok)                 stat = ST_BAD_COMP;
				else if (has_dest && !dest_ok)     stat = ST_BAD_DEST;
				else if (has_jump && !jump_ok)     stat = ST_BAD_JUMP;
				else word = {3'b111, has_m, comp_hit[5:0],
					has_dest ? dbits : 3'b000, has_jump ? jump_hit[2:0] : 3'b000};
			end
			KIND_OTHER: stat = ST_NOT_INSTR;
			default:    stat = ST_OK;
		endcase
	end

	assign machine_word = word;
	assign status       = stat;

endmodule

/* hdl/hack_instruction_text_encoder.sv */
// Channel | Signals                        | Word
// in      | in_valid, in_ready, char_code  | one ASCII character, LF ends a line
// out     | out_valid, out_ready,          | one encoded instruction per
//         | machine_word, status           | non-empty line
// One character per cycle: input register, then line-state update and the
// end-of-line encode, then the result register. An LF's word is written to the result
// register as the LF leaves the input register. CR is dropped; empty lines emit nothing.
// Reset clears the line state and both valid flags. An LF only waits when the
// result register is still full and not being taken.
// Depends on hte_pkg and hte_line_decode.
module hack_instruction_text_encoder #(
	parameter int FIELD_CHARS = hte_pkg::FIELD_CHARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hte_pkg::char_t      char_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         machine_word,
	output logic [2:0]          status
);
	import hte_pkg::*;

	localparam int LEN_W = $clog2(FIELD_CHARS + 2);
	localparam int IDX_W = $clog2(FIELD_CHARS);

	logic             valid_s1;
	char_t            char_s1;
	line_state_t      st_q;
	char_t            chars_q [3][FIELD_CHARS];
	logic [LEN_W-1:0] lens_q  [3];
	logic [15:0]      word_q;
	logic [2:0]       status_q;
	logic             out_valid_q;

	logic             emit, adv_s1, is_digit, is_comp_start;
	logic             store_en;
	logic [1:0]       store_slot;
	logic [LEN_W-1:0] store_len;
	logic [18:0]      addr_next;
	logic [15:0]      dec_word;
	logic [2:0]       dec_status;

	assign emit     = (char_s1 == CH_LF) && (st_q.kind != KIND_EMPTY);
	assign adv_s1   = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	assign is_digit = (char_s1 >= CH_0) && (char_s1 <= CH_9);
	assign is_comp_start = (char_s1 == CH_D) || (char_s1 == CH_M) || (char_s1 == CH_A) ||
		(char_s1 == CH_0) || (char_s1 == CH_NEG) || (char_s1 == CH_NOT) || (char_s1 == CH_1);
	// acc * 10 + digit
	assign addr_next = {1'b0, st_q.addr, 3'b000} + {3'b000, st_q.addr, 1'b0} +
		{15'd0, char_s1[3:0]};

	always_comb begin
		store_en   = 1'b0;
		store_slot = 2'd0;
		if (adv_s1 && char_s1 != CH_LF && char_s1 != CH_CR) begin
			if (st_q.kind == KIND_EMPTY) begin
				store_en = is_comp_start;
			end else if (st_q.kind == KIND_COMP && char_s1 != CH_EQ && char_s1 != CH_SEMI) begin
				store_en   = 1'b1;
				store_slot = (st_q.section >= SEC_JUMP_D) ? 2'd2 : st_q.section;
			end
		end
		store_len = lens_q[store_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) char_s1 <= char_code;
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			for (int s = 0; s < 3; s++) lens_q[s] <= '0;
		end else if (adv_s1 && char_s1 != CH_CR) begin
			if (char_s1 == CH_LF) begin
				st_q <= '0;
				for (int s = 0; s < 3; s++) lens_q[s] <= '0;
			end else begin
				if (store_en && store_len <= LEN_W'(FIELD_CHARS))
					lens_q[store_slot] <= store_len + LEN_W'(1);
				unique case (st_q.kind)
					KIND_EMPTY: begin
						if (char_s1 == CH_AT)    st_q.kind <= KIND_ADDR;
						else if (is_comp_start)  st_q.kind <= KIND_COMP;
						else                     st_q.kind <= KIND_OTHER;
					end
					KIND_ADDR: begin
						if (is_digit) begin
							st_q.addr_seen <= 1'b1;
							if (addr_next > {4'd0, ADDR_MAX}) begin
								st_q.addr_over <= 1'b1;
								st_q.addr      <= ADDR_MAX;
							end else begin
								st_q.addr <= addr_next[14:0];
							end
						end else if (st_q.err == ST_OK) begin
							st_q.err <= ST_NOT_INSTR;
						end
					end
					KIND_COMP: begin
						if (char_s1 == CH_EQ) begin
							if (st_q.section == SEC_FIRST) st_q.section <= SEC_COMP;
							else if (st_q.err == ST_OK)
								st_q.err <= (st_q.section == SEC_COMP) ? ST_BAD_DEST : ST_BAD_JUMP;
						end else if (char_s1 == CH_SEMI) begin
							if (st_q.section == SEC_FIRST)     st_q.section <= SEC_JUMP;
							else if (st_q.section == SEC_COMP) st_q.section <= SEC_JUMP_D;
							else if (st_q.err == ST_OK)        st_q.err <= ST_BAD_JUMP;
						end
					end
					default: st_q <= st_q;
				endcase
			end
		end
	end

	// field text, no reset: only entries written earlier in the line are read
	always_ff @(posedge clk) begin
		if (store_en && store_len < LEN_W'(FIELD_CHARS))
			chars_q[store_slot][store_len[IDX_W-1:0]] <= char_s1;
	end

	hte_line_decode #(
		.FIELD_CHARS (FIELD_CHARS)
	) u_decode (
		.st           (st_q),
		.chars        (chars_q),
		.lens         (lens_q),
		.machine_word (dec_word),
		.status       (dec_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			word_q   <= dec_word;
			status_q <= dec_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign machine_word = word_q;
	assign status       = status_q;

endmodule

/* bench/tb_hack_instruction_text_encoder.sv */
// Testbench for hack_instruction_text_encoder: directed source lines, then random
// well-formed and broken lines, checked against typed rows or an in-bench encoder.
// Depends on hte_pkg and the encoder RTL.
module tb_hack_instruction_text_encoder;
	timeunit 1ns;
	timeprecision 1ps;
	import hte_pkg::*;

	localparam int FLD         = FIELD_CHARS_DEF;
	localparam int ITEMS       = 1100;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int DIR_ROWS    = 28;

	// comp mnemonics, text right-justified, with their cccccc codes
	localparam logic [23:0] COMP_TXT [18] = '{"0", "1", "-1", "D", "A", "!D", "!A", "-D",
		"-A", "D+1", "A+1", "D-1", "A-1", "D+A", "D-A", "A-D", "D&A", "D|A"};
	localparam int COMP_LEN [18] = '{1, 1, 2, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3, 3, 3, 3, 3, 3};
	localparam logic [5:0] COMP_VAL [18] = '{6'h2A, 6'h3F, 6'h3A, 6'h0C, 6'h30, 6'h0D,
		6'h31, 6'h0F, 6'h33, 6'h1F, 6'h37, 6'h0E, 6'h32, 6'h02, 6'h13, 6'h07, 6'h00, 6'h15};
	// jump suffixes after 'J'; code is index + 1
	localparam logic [15:0] JUMP_TXT [7] = '{"GT", "EQ", "GE", "LT", "NE", "LE", "MP"};

	typedef struct packed {
		logic [15:0] word;
		logic [2:0]  st;
	} result_t;

	typedef struct {
		string       text;
		bit          typed;
		logic [15:0] word;
		logic [2:0]  st;
	} line_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	char_t       char_code;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] machine_word;
	logic [2:0]  status;

	result_t pending_words [$];
	char_t   line_buf [$];
	int      errors = 0;
	int      sent_chars = 0;
	bit      calm = 0;
	bit      hold_req = 0;

	// encoder line state
	logic [1:0]  p_kind;
	logic [1:0]  p_sect;
	logic [14:0] p_addr;
	logic        p_over;
	logic        p_digits;
	logic [2:0]  p_err;
	char_t       p_chars [3][FLD];
	int          p_len [3];

	line_row_t dir_rows [DIR_ROWS] = '{
		'{"@0",          1, 16'h0000, ST_OK},
		'{"@32767",      1, 16'h7FFF, ST_OK},
		'{"@32768",      1, 16'h0000, ST_ADDR_OVER},
		'{"@000123456",  1, 16'h0000, ST_ADDR_OVER},
		'{"@",           1, 16'h0000, ST_NOT_INSTR},
		'{"@99999x",     1, 16'h0000, ST_NOT_INSTR},
		'{"@1\0152",     0, 16'h0000, ST_OK},
		'{"",            0, 16'h0000, ST_OK},
		'{"\015",        0, 16'h0000, ST_OK},
		'{"X=D",         1, 16'h0000, ST_NOT_INSTR},
		'{"\377\200",    1, 16'h0000, ST_NOT_INSTR},
		'{"D=M\015",     1, 16'hFC10, ST_OK},
		'{"0;JMP",       1, 16'hEA87, ST_OK},
		'{"AMD=M+1;JGE", 1, 16'hFDFB, ST_OK},
		'{"MDA=1",       0, 16'h0000, ST_OK},
		'{"D=D|A;JNE",   0, 16'h0000, ST_OK},
		'{"-1;JLT",      0, 16'h0000, ST_OK},
		'{"M=!M",        0, 16'h0000, ST_OK},
		'{"D=A+M",       1, 16'h0000, ST_BAD_COMP},
		'{"D+1+1",       1, 16'h0000, ST_BAD_COMP},
		'{"D=",          1, 16'h0000, ST_BAD_COMP},
		'{"DD=D",        1, 16'h0000, ST_BAD_DEST},
		'{"AMDM=0",      1, 16'h0000, ST_BAD_DEST},
		'{"D=D=A",       1, 16'h0000, ST_BAD_DEST},
		'{"D;J=",        1, 16'h0000, ST_BAD_JUMP},
		'{"D;JMP;",      1, 16'h0000, ST_BAD_JUMP},
		'{"D;",          1, 16'h0000, ST_BAD_JUMP},
		'{"D;JEG",       1, 16'h0000, ST_BAD_JUMP}
	};

	hack_instruction_text_encoder #(.FIELD_CHARS(FLD)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.machine_word(machine_word),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_line();
		p_kind = KIND_EMPTY;
		p_sect = SEC_FIRST;
		p_addr = '0;
		p_over = 1'b0;
		p_digits = 1'b0;
		p_err = ST_OK;
		for (int s = 0; s < 3; s++) p_len[s] = 0;
	endfunction

	function automatic void note_error(input logic [2:0] code);
		if (p_err == ST_OK) p_err = code;
	endfunction

	// overlong fields keep counting to FLD + 1 so they match nothing
	function automatic void keep_char(input int slot, input char_t c);
		if (p_len[slot] < FLD) p_chars[slot][p_len[slot]] = c;
		if (p_len[slot] <= FLD) p_len[slot]++;
	endfunction

	function automatic int comp_bits(input int slot);
		int n;
		logic [23:0] key;
		logic has_a, has_m;
		char_t c;
		n = p_len[slot];
		if (n == 0 || n > 3 || n > FLD) return -1;
		key = '0;
		has_a = 1'b0;
		has_m = 1'b0;
		for (int i = 0; i < n; i++) begin
			c = p_chars[slot][i];
			if (c == CH_A) has_a = 1'b1;
			if (c == CH_M) begin
				has_m = 1'b1;
				c = CH_A;
			end
			key = {key[15:0], c};
		end
		if (has_a && has_m) return -1;
		for (int k = 0; k < 18; k++)
			if (COMP_LEN[k] == n && COMP_TXT[k] == key) return int'({has_m, COMP_VAL[k]});
		return -1;
	endfunction

	function automatic int dest_bits();
		int n, bits, b;
		char_t c;
		n = p_len[0];
		if (n == 0 || n > 3 || n > FLD) return -1;
		bits = 0;
		for (int i = 0; i < n; i++) begin
			c = p_chars[0][i];
			b = (c == CH_A) ? 4 : (c == CH_D) ? 2 : (c == CH_M) ? 1 : 0;
			if (b == 0 || (bits & b) != 0) return -1;
			bits |= b;
		end
		return bits;
	endfunction

	function automatic int jump_bits();
		if (p_len[2] != 3 || FLD < 3 || p_chars[2][0] != CH_J) return -1;
		for (int k = 0; k < 7; k++)
			if ({p_chars[2][1], p_chars[2][2]} == JUMP_TXT[k]) return k + 1;
		return -1;
	endfunction

	// advance the line state by one accepted character; at LF queue the word it yields
	task automatic track_char(input char_t c, input bit typed, input result_t typed_res);
		result_t r;
		int cv, dv, jv, nxt;
		logic has_dest, has_jump;
		if (c == CH_CR) return;
		if (c != CH_LF) begin
			case (p_kind)
				KIND_EMPTY: begin
					if (c == CH_AT) p_kind = KIND_ADDR;
					else if (c == CH_D || c == CH_M || c == CH_A || c == CH_0 ||
							c == CH_NEG || c == CH_NOT || c == CH_1) begin
						p_kind = KIND_COMP;
						keep_char(0, c);
					end else p_kind = KIND_OTHER;
				end
				KIND_ADDR: begin
					if (c >= CH_0 && c <= CH_9) begin
						nxt = int'(p_addr) * 10 + int'(c - CH_0);
						if (nxt > int'(ADDR_MAX)) begin
							p_over = 1'b1;
							nxt = int'(ADDR_MAX);
						end
						p_addr = nxt[14:0];
						p_digits = 1'b1;
					end else note_error(ST_NOT_INSTR);
				end
				KIND_COMP: begin
					if (c == CH_EQ) begin
						if (p_sect == SEC_FIRST) p_sect = SEC_COMP;
						else note_error(p_sect == SEC_COMP ? ST_BAD_DEST : ST_BAD_JUMP);
					end else if (c == CH_SEMI) begin
						if (p_sect == SEC_FIRST) p_sect = SEC_JUMP;
						else if (p_sect == SEC_COMP) p_sect = SEC_JUMP_D;
						else note_error(ST_BAD_JUMP);
					end else keep_char(p_sect >= SEC_JUMP_D ? 2 : int'(p_sect), c);
				end
				default: ;
			endcase
			return;
		end
		if (p_kind == KIND_EMPTY) begin
			clear_line();
			return;
		end
		r.word = 16'h0000;
		r.st = ST_OK;
		if (p_kind == KIND_OTHER) r.st = ST_NOT_INSTR;
		else if (p_kind == KIND_ADDR) begin
			if (p_err != ST_OK || !p_digits) r.st = ST_NOT_INSTR;
			else if (p_over) r.st = ST_ADDR_OVER;
			else r.word = {1'b0, p_addr};
		end else if (p_err != ST_OK) r.st = p_err;
		else begin
			has_dest = p_sect == SEC_COMP || p_sect == SEC_JUMP_D;
			has_jump = p_sect == SEC_JUMP_D || p_sect == SEC_JUMP;
			cv = comp_bits(has_dest ? 1 : 0);
			dv = has_dest ? dest_bits() : 0;
			jv = has_jump ? jump_bits() : 0;
			if (cv < 0) r.st = ST_BAD_COMP;
			else if (dv < 0) r.st = ST_BAD_DEST;
			else if (jv < 0) r.st = ST_BAD_JUMP;
			else r.word = {3'b111, cv[6:0], dv[2:0], jv[2:0]};
		end
		clear_line();
		pending_words.push_back(typed ? typed_res : r);
	endtask

	function automatic char_t any_byte();
		char_t b;
		do b = char_t'($urandom_range(0, 255)); while (b == CH_LF);
		return b;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	// [dest=]comp[;jump] from the tables, with an occasional bad dest or jump
	task automatic add_compute();
		int k, bits, j;
		logic use_m;
		char_t c, tmp;
		char_t dst [$];
		if ($urandom_range(0, 1)) begin
			bits = $urandom_range(1, 7);
			if (bits[2]) dst.push_back(CH_A);
			if (bits[1]) dst.push_back(CH_D);
			if (bits[0]) dst.push_back(CH_M);
			for (int i = 0; i < dst.size(); i++) begin
				j = $urandom_range(0, dst.size() - 1);
				tmp = dst[i];
				dst[i] = dst[j];
				dst[j] = tmp;
			end
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: dst.push_back(CH_A);
					1: dst.push_back(CH_D);
					2: dst.push_back(CH_M);
					default: dst.push_back("X");
				endcase
			end
			foreach (dst[i]) line_buf.push_back(dst[i]);
			line_buf.push_back(CH_EQ);
		end
		k = $urandom_range(0, 17);
		use_m = $urandom_range(0, 1);
		for (int i = 0; i < COMP_LEN[k]; i++) begin
			c = COMP_TXT[k][8 * (COMP_LEN[k] - 1 - i) +: 8];
			if (use_m && c == CH_A) c = CH_M;
			line_buf.push_back(c);
		end
		if ($urandom_range(0, 1)) begin
			line_buf.push_back(CH_SEMI);
			line_buf.push_back(CH_J);
			if ($urandom_range(0, 9) == 0) begin
				line_buf.push_back(char_t'($urandom_range(65, 90)));
				line_buf.push_back(char_t'($urandom_range(65, 90)));
			end else begin
				k = $urandom_range(0, 6);
				line_buf.push_back(JUMP_TXT[k][15:8]);
				line_buf.push_back(JUMP_TXT[k][7:0]);
			end
		end
	endtask

	// one random source line without its LF
	task automatic make_line();
		int pick, k, n;
		line_buf.delete();
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			line_buf.push_back(CH_AT);
			k = $urandom_range(0, 7);
			if (k == 0) begin
				n = $urandom_range(0, 7);
				for (int i = 0; i < n; i++)
					line_buf.push_back(CH_0 + char_t'($urandom_range(0, 9)));
			end else if (k == 1) push_text($sformatf("%0d", $urandom_range(32760, 40000)));
			else push_text($sformatf("%0d", $urandom_range(0, 32767)));
		end else if (pick < 85) begin
			add_compute();
			if (pick >= 75) begin
				case ($urandom_range(0, 2))
					0: line_buf[$urandom_range(0, line_buf.size() - 1)] = any_byte();
					1: line_buf.insert($urandom_range(0, line_buf.size()),
							$urandom_range(0, 1) ? CH_EQ : CH_SEMI);
					default: void'(line_buf.pop_back());
				endcase
			end
		end else if (pick >= 92) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) line_buf.push_back(any_byte());
		end
		if ($urandom_range(0, 9) == 0)
			line_buf.insert($urandom_range(0, line_buf.size()), CH_CR);
	endtask

	task automatic send_char(input char_t c, input bit typed, input result_t typed_res);
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (!in_ready);
		track_char(c, typed, typed_res);
		sent_chars++;
	endtask

	task automatic check_word();
		result_t want;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected word %h status %0d", $time, machine_word, status);
			errors++;
			return;
		end
		want = pending_words.pop_front();
		if (machine_word !== want.word) begin
			$display("%0t: machine_word expected %h actual %h", $time, want.word, machine_word);
			errors++;
		end
		if (status !== want.st) begin
			$display("%0t: status expected %0d actual %0d", $time, want.st, status);
			errors++;
		end
	endtask

	initial begin : stimulus
		int lines;
		result_t none;
		none = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		clear_line();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < DIR_ROWS; r++) begin
			for (int i = 0; i < dir_rows[r].text.len(); i++)
				send_char(dir_rows[r].text[i], 1'b0, none);
			send_char(CH_LF, dir_rows[r].typed, '{dir_rows[r].word, dir_rows[r].st});
		end
		lines = 0;
		while (sent_chars < ITEMS) begin
			make_line();
			// long output stall while input keeps coming
			if (lines == 25) hold_req = 1'b1;
			if (sent_chars >= ITEMS - 150) calm = 1'b1;
			foreach (line_buf[i]) send_char(line_buf[i], 1'b0, none);
			send_char(CH_LF, 1'b0, none);
			lines++;
		end
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** hack_instruction_text_encoder: PASSED **");
		else
			$display("** hack_instruction_text_encoder: FAILED **");
		$finish;
	end

	initial begin : drain
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) check_word();
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				out_ready <= 1'b0;
			end else out_ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("** hack_instruction_text_encoder: FAILED **");
		$finish;
	end

endmodule
